// ===== design/fixed_point_alu_macros.svh =====
// Assertion macros shared by the fixed-point ALU checker.
// Expects signals named clock and reset in the scope of each use.
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH

// Checked only while reset is low.
`define FPA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, including during reset.
`define FPA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/fpa_pkg.sv =====
// Package for the fixed-point ALU: word format, opcodes, classes and shared types.
// Depends on nothing; fpa_front, fpa_queue, fpa_back and the top level import it.
`default_nettype none
package fpa_pkg;
   localparam int PORT_WIDTH = 32;
   localparam int WORD_WIDTH = 32;
   localparam int FRAC_BITS  = 8;
   localparam int DIV_WIDTH  = WORD_WIDTH + FRAC_BITS;

   localparam logic [3:0] OP_ADD      = 4'd0;
   localparam logic [3:0] OP_SUB      = 4'd1;
   localparam logic [3:0] OP_MUL      = 4'd2;
   localparam logic [3:0] OP_DIV      = 4'd3;
   localparam logic [3:0] OP_GT       = 4'd4;
   localparam logic [3:0] OP_GE       = 4'd5;
   localparam logic [3:0] OP_LT       = 4'd6;
   localparam logic [3:0] OP_LE       = 4'd7;
   localparam logic [3:0] OP_EQ       = 4'd8;
   localparam logic [3:0] OP_NE       = 4'd9;
   localparam logic [3:0] OP_MAX      = 4'd10;
   localparam logic [3:0] OP_MIN      = 4'd11;
   localparam logic [3:0] OP_INC      = 4'd12;
   localparam logic [3:0] OP_DEC      = 4'd13;
   localparam logic [3:0] OP_FROM_INT = 4'd14;
   localparam logic [3:0] OP_TO_INT   = 4'd15;

   localparam logic [1:0] CLS_SIMPLE = 2'd0;
   localparam logic [1:0] CLS_MUL    = 2'd1;
   localparam logic [1:0] CLS_DIV    = 2'd2;
   localparam logic [1:0] CLS_CMP    = 2'd3;

   typedef struct packed {
      logic [1:0]                   cls;
      logic [3:0]                   opcode;
      logic signed [WORD_WIDTH-1:0] operand_a;
      logic signed [WORD_WIDTH-1:0] operand_b;
   } item_type;

   typedef struct packed {
      logic [1:0]                   cls;
      logic                         cmp;
      logic                         dz;
      logic                         neg;
      logic signed [WORD_WIDTH-1:0] value;
      logic [WORD_WIDTH-1:0]        rem;
      logic [DIV_WIDTH-1:0]         dvd;
      logic [WORD_WIDTH-1:0]        dsr;
   } stage_type;
endpackage
`default_nettype wire

// ===== design/fpa_front.sv =====
// Front stage: registers an incoming transaction and tags it with its operation class.
// Depends on fpa_pkg.
`default_nettype none
module fpa_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output      logic                 req_full,
   input  wire logic [3:0]           req_opcode,
   input  wire logic signed [31:0]   req_operand_a,
   input  wire logic signed [31:0]   req_operand_b,
   input  wire logic                 q_full,
   output      logic                 q_push,
   output      fpa_pkg::item_type    q_item
);
   import fpa_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   assign req_full = valid_ff & q_full;
   assign accept   = req_push & ~req_full;
   assign q_push   = valid_ff & ~q_full;
   assign q_item   = item_ff;

   always_comb begin
      item_in           = item_ff;
      valid_in          = valid_ff & q_full;
      if (accept) begin
         valid_in           = 1'b1;
         item_in.opcode     = req_opcode;
         item_in.operand_a  = req_operand_a[WORD_WIDTH-1:0];
         item_in.operand_b  = req_operand_b[WORD_WIDTH-1:0];
         case (req_opcode)
            OP_MUL: begin
               item_in.cls = CLS_MUL;
            end
            OP_DIV: begin
               item_in.cls = CLS_DIV;
            end
            OP_GT, OP_GE, OP_LT, OP_LE, OP_EQ, OP_NE: begin
               item_in.cls = CLS_CMP;
            end
            default: begin
               item_in.cls = CLS_SIMPLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end
endmodule
`default_nettype wire

// ===== design/fpa_queue.sv =====
// Two-entry queue that decouples the front stage from the execution pipeline.
// Depends on fpa_pkg.
`default_nettype none
module fpa_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire fpa_pkg::item_type push_item,
   output      logic              full,
   input  wire logic              pop,
   output      logic              not_empty,
   output      fpa_pkg::item_type head_item
);
   import fpa_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

// ===== design/fpa_back.sv =====
// Execution pipeline: operand stage, multiplier, one divider step per stage, result register.
// Depends on fpa_pkg.
`default_nettype none
module fpa_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_not_empty,
   input  wire fpa_pkg::item_type    q_item,
   output      logic                 q_pop,
   output      logic                 rsp_empty,
   input  wire logic                 rsp_pop,
   output      logic signed [31:0]   rsp_result_value,
   output      logic                 rsp_compare_true,
   output      logic                 rsp_divide_by_zero
);
   import fpa_pkg::*;

   localparam int W = WORD_WIDTH;

   logic                     move;
   logic                     valid_ff [0:DIV_WIDTH];
   stage_type                stage_ff [0:DIV_WIDTH];
   stage_type                stage_in [0:DIV_WIDTH];
   logic signed [2*W-1:0]    product_ff, product_in;
   logic                     out_valid_ff, out_valid_in;
   logic signed [W-1:0]      out_value_ff, out_value_in;
   logic                     out_cmp_ff, out_cmp_in;
   logic                     out_dz_ff, out_dz_in;

   logic signed [W-1:0] a_w, b_w;
   logic [W-1:0]        mag_a, mag_b, quo;

   assign move  = ~out_valid_ff | rsp_pop;
   assign q_pop = move & q_not_empty;

   always_comb begin
      a_w        = q_item.operand_a;
      b_w        = q_item.operand_b;
      mag_a      = a_w[W-1] ? (~a_w + 1'b1) : a_w;
      mag_b      = b_w[W-1] ? (~b_w + 1'b1) : b_w;
      product_in = a_w * b_w;
      stage_in[0]       = '0;
      stage_in[0].cls   = q_item.cls;
      stage_in[0].neg   = a_w[W-1] ^ b_w[W-1];
      stage_in[0].dz    = (q_item.cls == CLS_DIV) && (b_w == '0);
      stage_in[0].dvd   = {mag_a, {FRAC_BITS{1'b0}}};
      stage_in[0].dsr   = mag_b;
      case (q_item.opcode)
         OP_ADD:      stage_in[0].value = a_w + b_w;
         OP_SUB:      stage_in[0].value = a_w - b_w;
         OP_GT:       stage_in[0].cmp   = a_w > b_w;
         OP_GE:       stage_in[0].cmp   = a_w >= b_w;
         OP_LT:       stage_in[0].cmp   = a_w < b_w;
         OP_LE:       stage_in[0].cmp   = a_w <= b_w;
         OP_EQ:       stage_in[0].cmp   = a_w == b_w;
         OP_NE:       stage_in[0].cmp   = a_w != b_w;
         OP_MAX:      stage_in[0].value = (a_w > b_w) ? a_w : b_w;
         OP_MIN:      stage_in[0].value = (a_w < b_w) ? a_w : b_w;
         OP_INC:      stage_in[0].value = a_w + W'(1);
         OP_DEC:      stage_in[0].value = a_w - W'(1);
         OP_FROM_INT: stage_in[0].value = a_w <<< FRAC_BITS;
         OP_TO_INT:   stage_in[0].value = a_w >>> FRAC_BITS;
         default:     stage_in[0].value = '0;
      endcase
   end

   for (genvar k = 0; k < DIV_WIDTH; k++) begin : g_step
      logic [W:0] trial, diff;
      logic       ge;
      always_comb begin
         trial = {stage_ff[k].rem, stage_ff[k].dvd[DIV_WIDTH-1]};
         diff  = trial - {1'b0, stage_ff[k].dsr};
         ge    = (trial >= {1'b0, stage_ff[k].dsr});
         stage_in[k+1]     = stage_ff[k];
         stage_in[k+1].rem = ge ? diff[W-1:0] : trial[W-1:0];
         stage_in[k+1].dvd = {stage_ff[k].dvd[DIV_WIDTH-2:0], ge};
         if (k == 0 && stage_ff[k].cls == CLS_MUL) begin
            stage_in[k+1].value = product_ff[FRAC_BITS+W-1:FRAC_BITS];
         end
      end
   end

   always_comb begin
      quo          = stage_ff[DIV_WIDTH].dvd[W-1:0];
      out_value_in = stage_ff[DIV_WIDTH].value;
      if (stage_ff[DIV_WIDTH].cls == CLS_DIV) begin
         if (stage_ff[DIV_WIDTH].dz) begin
            out_value_in = '0;
         end else if (stage_ff[DIV_WIDTH].neg) begin
            out_value_in = ~quo + 1'b1;
         end else begin
            out_value_in = quo;
         end
      end
      out_cmp_in   = stage_ff[DIV_WIDTH].cmp;
      out_dz_in    = stage_ff[DIV_WIDTH].dz;
      out_valid_in = move ? valid_ff[DIV_WIDTH] : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV_WIDTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (move) begin
            valid_ff[0] <= q_not_empty;
            for (int i = 1; i <= DIV_WIDTH; i++) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
      if (move) begin
         product_ff <= product_in;
         for (int i = 0; i <= DIV_WIDTH; i++) begin
            stage_ff[i] <= stage_in[i];
         end
         out_value_ff <= out_value_in;
         out_cmp_ff   <= out_cmp_in;
         out_dz_ff    <= out_dz_in;
      end
   end

   assign rsp_empty          = ~out_valid_ff;
   assign rsp_result_value   = PORT_WIDTH'(out_value_ff);
   assign rsp_compare_true   = out_cmp_ff;
   assign rsp_divide_by_zero = out_dz_ff;
endmodule
`default_nettype wire

// ===== design/fixed_point_alu.sv =====
// A request passes the front register (loaded on the accepting edge), the queue, the
// operand stage, 40 divider steps and the result register. The pipelined restoring
// divider takes one transaction per cycle unless a held result stalls the pipeline.
// Reset is synchronous and active high; it empties the queue and the pipeline.
// Top level of the fixed-point ALU; depends on fpa_pkg, fpa_front, fpa_queue, fpa_back.
`default_nettype none
module fixed_point_alu (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output      logic               req_full,
   input  wire logic [3:0]         req_opcode,
   input  wire logic signed [31:0] req_operand_a,
   input  wire logic signed [31:0] req_operand_b,
   output      logic               rsp_empty,
   input  wire logic               rsp_pop,
   output      logic signed [31:0] rsp_result_value,
   output      logic               rsp_compare_true,
   output      logic               rsp_divide_by_zero
);
   import fpa_pkg::*;

   logic     q_full, q_push, q_pop, q_not_empty;
   item_type push_item, head_item;

   fpa_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_opcode    (req_opcode),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (push_item)
   );

   fpa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   fpa_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_not_empty        (q_not_empty),
      .q_item             (head_item),
      .q_pop              (q_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_result_value   (rsp_result_value),
      .rsp_compare_true   (rsp_compare_true),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );
endmodule
`default_nettype wire

// ===== design/fpa_checker.sv =====
// Port-level checker for the fixed-point ALU, bound to the top level.
// Depends on fixed_point_alu_macros.svh.
`default_nettype none
`include "fixed_point_alu_macros.svh"
module fpa_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_empty,
   input wire logic               rsp_pop,
   input wire logic signed [31:0] rsp_result_value,
   input wire logic               rsp_compare_true,
   input wire logic               rsp_divide_by_zero
);
   `FPA_ASSERT_ALWAYS(a_reset_empty, reset |=> rsp_empty, "Result queue not empty after reset")
   `FPA_ASSERT(a_hold, (!rsp_empty && !rsp_pop) |=> !rsp_empty, "Waiting result was dropped")
   `FPA_ASSERT(a_flags, !rsp_empty |-> !(rsp_compare_true && rsp_divide_by_zero),
      "Both flags set")
   `FPA_ASSERT(a_dz_zero, (!rsp_empty && rsp_divide_by_zero) |-> (rsp_result_value == 0),
      "Divide by zero with nonzero value")
   `FPA_ASSERT(a_cmp_zero, (!rsp_empty && rsp_compare_true) |-> (rsp_result_value == 0),
      "Comparison with nonzero value")
endmodule

bind fixed_point_alu fpa_checker u_checker (.*);
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the fixed-point ALU: directed and random operations
// with bursty input and a stalling result side. Depends on fpa_pkg and fixed_point_alu.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fpa_pkg::*;

   typedef struct {
      logic signed [31:0] value;
      logic               cmp;
      logic               dz;
   } alu_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [3:0]         req_opcode = OP_ADD;
   logic signed [31:0] req_operand_a = '0;
   logic signed [31:0] req_operand_b = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic signed [31:0] rsp_result_value;
   logic               rsp_compare_true;
   logic               rsp_divide_by_zero;

   alu_result_type expected_results[$];
   int  mismatch_count = 0;
   int  hold_cycles = 0;

   fixed_point_alu DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic alu_result_type compute_alu(logic [3:0] op, logic signed [31:0] a,
                                                  logic signed [31:0] b);
      alu_result_type r;
      logic signed [63:0] wa, wb, wide;
      wa = a;
      wb = b;
      r.value = '0;
      r.cmp = 1'b0;
      r.dz = 1'b0;
      case (op)
         OP_ADD: r.value = a + b;
         OP_SUB: r.value = a - b;
         OP_MUL: begin
            wide = wa * wb;
            wide = wide >>> FRAC_BITS;
            r.value = wide[31:0];
         end
         OP_DIV: begin
            if (b == 0) begin
               r.dz = 1'b1;
            end else begin
               wide = (wa <<< FRAC_BITS) / wb;
               r.value = wide[31:0];
            end
         end
         OP_GT: r.cmp = a > b;
         OP_GE: r.cmp = a >= b;
         OP_LT: r.cmp = a < b;
         OP_LE: r.cmp = a <= b;
         OP_EQ: r.cmp = a == b;
         OP_NE: r.cmp = a != b;
         OP_MAX: r.value = (a > b) ? a : b;
         OP_MIN: r.value = (a < b) ? a : b;
         OP_INC: r.value = a + 32'sd1;
         OP_DEC: r.value = a - 32'sd1;
         OP_FROM_INT: r.value = a <<< FRAC_BITS;
         default: r.value = a >>> FRAC_BITS;
      endcase
      return r;
   endfunction

   task automatic send_operation(logic [3:0] op, logic signed [31:0] a,
                                 logic signed [31:0] b);
      req_push <= 1'b1;
      req_opcode <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      expected_results.push_back(compute_alu(op, a, b));
   endtask

   function automatic logic signed [31:0] random_operand();
      case ($urandom_range(0, 5))
         0: return 32'sh8000_0000 + $urandom_range(0, 3);
         1: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
         2: return $signed($urandom_range(0, 8)) - 4;
         3: return $signed($urandom_range(0, 2047)) - 1024;
         default: return $urandom;
      endcase
   endfunction

   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      logic signed [31:0] corners[6];
      corners = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1, 1, 32'sh100};
      for (int op = 0; op < 16; op++)
         send_operation(op[3:0], corners[op % 6], corners[(op + 2) % 6]);
      send_operation(OP_DIV, 32'sh100, 0);
      send_operation(OP_DIV, 32'sh8000_0000, -1);
      send_operation(OP_MUL, 32'sh8000_0000, 32'sh8000_0000);
      send_operation(OP_MAX, 32'sh1234, 32'sh1234);
      send_operation(OP_MIN, -5, -5);
      send_operation(OP_TO_INT, -1, 0);
      send_operation(OP_FROM_INT, 32'sh7FFF_FFFF, 0);
      send_operation(OP_INC, 32'sh7FFF_FFFF, 0);
      send_operation(OP_DEC, 32'sh8000_0000, 0);
   endtask

   task automatic test_random(int count);
      int sent;
      int burst;
      int gap;
      logic signed [31:0] a;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && sent < count; i++) begin
            a = random_operand();
            send_operation(4'($urandom_range(0, 15)), a,
                           ($urandom_range(0, 9) == 0) ? a : random_operand());
            sent++;
         end
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 200;
      for (int i = 0; i < 100; i++)
         send_operation(4'($urandom_range(0, 15)), random_operand(), random_operand());
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected transaction: value %h", rsp_result_value);
            end else begin
               alu_result_type e;
               e = expected_results.pop_front();
               if (e.value !== rsp_result_value || e.cmp !== rsp_compare_true
                   || e.dz !== rsp_divide_by_zero) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected %h/%b/%b, got %h/%b/%b", e.value, e.cmp,
                              e.dz, rsp_result_value, rsp_compare_true,
                              rsp_divide_by_zero);
               end
            end
         end
         if (hold_cycles > 0) begin
            rsp_pop <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) < 30) ? 1'b0 : ($urandom_range(0, 3) != 0);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("testbench: errors");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drained();
      test_backpressure();
      test_random(1300);
      wait_drained();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== fixed_point_alu.f =====
+incdir+design
design/fpa_pkg.sv
design/fpa_front.sv
design/fpa_queue.sv
design/fpa_back.sv
design/fixed_point_alu.sv
design/fpa_checker.sv
dv/testbench.sv
